// File: rtl/core/rtad_pkg.sv
package rtad_pkg;

    localparam int SUM_W   = 20;
    localparam int PIX_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 11;
    localparam int QUO_W   = 9;

    localparam int MAX_IMAGE_WIDTH = 1024;
    localparam int MAX_TILE_SIZE   = 64;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sum3_t;

    typedef struct packed {
        logic       start;
        logic       busy;
        logic       done;
    } div_ctrl_t;

endpackage

// File: rtl/core/rtad_divider.sv
module rtad_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  rtad_pkg::sum3_t        sums,
    input  logic [12:0]            count,
    output rtad_pkg::div_ctrl_t    ctrl,
    output logic [7:0]             mean_r,
    output logic [7:0]             mean_g,
    output logic [7:0]             mean_b
);

    localparam int QW = rtad_pkg::SUM_W;

    logic [QW-1:0] rem_r_reg, rem_g_reg, rem_b_reg;
    logic [QW-1:0] num_r_reg, num_g_reg, num_b_reg;
    logic [4:0]    bit_reg;
    logic          busy_reg, done_reg;

    logic [QW-1:0] tr, tg, tb;
    logic [QW:0]   dr, dg, db;

    always_comb begin
        tr = {rem_r_reg[QW-2:0], num_r_reg[QW-1]};
        tg = {rem_g_reg[QW-2:0], num_g_reg[QW-1]};
        tb = {rem_b_reg[QW-2:0], num_b_reg[QW-1]};
        dr = {1'b0, tr} - {{(QW+1-13){1'b0}}, count};
        dg = {1'b0, tg} - {{(QW+1-13){1'b0}}, count};
        db = {1'b0, tb} - {{(QW+1-13){1'b0}}, count};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (bit_reg == '0);
            if (start) begin
                busy_reg  <= 1'b1;
                bit_reg   <= 5'(QW - 1);
                rem_r_reg <= '0;
                rem_g_reg <= '0;
                rem_b_reg <= '0;
                num_r_reg <= sums.r;
                num_g_reg <= sums.g;
                num_b_reg <= sums.b;
            end else if (busy_reg) begin
                rem_r_reg <= dr[QW] ? tr : dr[QW-1:0];
                rem_g_reg <= dg[QW] ? tg : dg[QW-1:0];
                rem_b_reg <= db[QW] ? tb : db[QW-1:0];
                num_r_reg <= {num_r_reg[QW-2:0], ~dr[QW]};
                num_g_reg <= {num_g_reg[QW-2:0], ~dg[QW]};
                num_b_reg <= {num_b_reg[QW-2:0], ~db[QW]};
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                end
                bit_reg <= bit_reg - 5'd1;
            end
        end
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
    assign mean_r = (|num_r_reg[QW-1:8]) ? 8'hFF : num_r_reg[7:0];
    assign mean_g = (|num_g_reg[QW-1:8]) ? 8'hFF : num_g_reg[7:0];
    assign mean_b = (|num_b_reg[QW-1:8]) ? 8'hFF : num_b_reg[7:0];

endmodule

// File: rtl/core/rgb_tile_average_downscale_core.sv
// Channel   Direction  Handshake                 Payload
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
// pixel     in         s_valid / s_ready         s_pixel_red/green/blue
// tile      out        m_valid / m_ready         m_mean_*, m_tile_col/row, m_frame_done
//
// A pixel that does not finish a tile goes through accept, memory read, and write
// back of the column sums. A pixel that finishes a tile then also passes through
// the bit-serial divider and the load of the output registers.
// Reset is synchronous and active low; the column sum memory needs no clearing.
// A waiting result does not hold the input; a second finished tile waits in the
// divider until the first result is taken.
module rgb_tile_average_downscale_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_red,
    input  logic [7:0]  s_pixel_green,
    input  logic [7:0]  s_pixel_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_mean_red,
    output logic [7:0]  m_mean_green,
    output logic [7:0]  m_mean_blue,
    output logic [9:0]  m_tile_col,
    output logic [9:0]  m_tile_row,
    output logic        m_frame_done
);

    localparam int MAX_IMAGE_WIDTH = rtad_pkg::MAX_IMAGE_WIDTH;
    localparam int MAX_TILE_SIZE   = rtad_pkg::MAX_TILE_SIZE;
    localparam int AW = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
    localparam int TW = $clog2(MAX_TILE_SIZE + 1);
    localparam int XW = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int HW = 11;
    localparam int PW = XW + TW;

    logic [10:0] iw_reg, ih_reg;
    logic [6:0]  tw_reg, th_reg;

    logic [XW-1:0] w;
    logic [HW-1:0] h;
    logic [TW-1:0] tw, th;
    always_comb begin
        w  = (iw_reg == '0) ? XW'(1) :
             ({1'b0, iw_reg} > 12'(MAX_IMAGE_WIDTH)) ? XW'(MAX_IMAGE_WIDTH) : XW'(iw_reg);
        h  = (ih_reg == '0) ? HW'(1) : (ih_reg > 11'd1024) ? HW'(1024) : ih_reg;
        tw = (tw_reg == '0) ? TW'(1) :
             ({2'b0, tw_reg} > 9'(MAX_TILE_SIZE)) ? TW'(MAX_TILE_SIZE) : TW'(tw_reg);
        th = (th_reg == '0) ? TW'(1) :
             ({2'b0, th_reg} > 9'(MAX_TILE_SIZE)) ? TW'(MAX_TILE_SIZE) : TW'(th_reg);
    end

    rtad_pkg::state_t state_reg, state_next;

    logic [XW-1:0] px_reg;
    logic [HW-1:0] py_reg;
    logic [TW-1:0] xt_reg, yt_reg;
    logic [XW-1:0] tx_reg;
    logic [HW-1:0] ty_reg;
    logic [PW-1:0] x_end, y_end;
    logic [12:0]   count_reg;
    logic [7:0]    pr_reg, pg_reg, pb_reg;
    logic          active_reg, last_reg, first_reg, fin_reg;
    logic [9:0]    col_reg, row_reg;
    logic          fd_reg;

    rtad_pkg::sum3_t mem [MAX_IMAGE_WIDTH];
    rtad_pkg::sum3_t rd_reg, new_sum;
    logic [AW-1:0]   addr_reg;

    logic accept, start, load;
    rtad_pkg::div_ctrl_t dctrl;
    logic [7:0] div_mean_r, div_mean_g, div_mean_b;
    logic [7:0] mean_r_reg, mean_g_reg, mean_b_reg;
    logic [9:0] col_out_reg, row_out_reg;
    logic       fd_out_reg;
    logic       m_valid_reg;

    logic read_phase_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == rtad_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        x_end = (PW'(tx_reg) + PW'(1)) * PW'(tw);
        y_end = (PW'(ty_reg) + PW'(1)) * PW'(th);
    end

    always_comb begin
        new_sum.r = (first_reg ? '0 : rd_reg.r) + rtad_pkg::SUM_W'(pr_reg);
        new_sum.g = (first_reg ? '0 : rd_reg.g) + rtad_pkg::SUM_W'(pg_reg);
        new_sum.b = (first_reg ? '0 : rd_reg.b) + rtad_pkg::SUM_W'(pb_reg);
    end

    assign start = (state_reg == rtad_pkg::ST_READ) && !read_phase_reg &&
                   active_reg && fin_reg;
    assign load  = ((state_reg == rtad_pkg::ST_DIV && dctrl.done) ||
                    state_reg == rtad_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rtad_pkg::ST_IDLE: if (accept) state_next = rtad_pkg::ST_READ;
            rtad_pkg::ST_READ: begin
                if (!read_phase_reg) state_next = start ? rtad_pkg::ST_DIV : rtad_pkg::ST_IDLE;
            end
            rtad_pkg::ST_DIV: begin
                if (dctrl.done) state_next = load ? rtad_pkg::ST_IDLE : rtad_pkg::ST_OUT;
            end
            rtad_pkg::ST_OUT: begin
                if (load) state_next = rtad_pkg::ST_IDLE;
            end
            default: state_next = rtad_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtad_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg <= 11'd32;
            ih_reg <= 11'd32;
            tw_reg <= 7'd16;
            th_reg <= 7'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rtad_pkg::REG_IMAGE_WIDTH:  iw_reg <= cfg_data;
                rtad_pkg::REG_IMAGE_HEIGHT: ih_reg <= cfg_data;
                rtad_pkg::REG_TILE_WIDTH:   tw_reg <= cfg_data[6:0];
                rtad_pkg::REG_TILE_HEIGHT:  th_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= 13'(tw) * 13'(th);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= '0; py_reg <= '0; xt_reg <= '0; yt_reg <= '0;
            tx_reg <= '0; ty_reg <= '0;
        end else if (accept) begin
            active_reg <= (x_end <= PW'(w)) && (y_end <= PW'(h)) &&
                          (tx_reg < XW'(MAX_IMAGE_WIDTH));
            first_reg  <= (xt_reg == '0) && (yt_reg == '0);
            fin_reg    <= (xt_reg == tw - TW'(1)) && (yt_reg == th - TW'(1));
            last_reg   <= (x_end + PW'(tw) > PW'(w)) && (y_end + PW'(th) > PW'(h));
            addr_reg   <= AW'(tx_reg);
            col_reg    <= 10'(tx_reg);
            row_reg    <= 10'(ty_reg);
            pr_reg <= s_pixel_red; pg_reg <= s_pixel_green; pb_reg <= s_pixel_blue;
            if (px_reg + XW'(1) >= w) begin
                px_reg <= '0; xt_reg <= '0; tx_reg <= '0;
                if (py_reg + HW'(1) >= h) begin
                    py_reg <= '0; yt_reg <= '0; ty_reg <= '0;
                end else begin
                    py_reg <= py_reg + HW'(1);
                    if (yt_reg + TW'(1) >= th) begin
                        yt_reg <= '0; ty_reg <= ty_reg + HW'(1);
                    end else begin
                        yt_reg <= yt_reg + TW'(1);
                    end
                end
            end else begin
                px_reg <= px_reg + XW'(1);
                if (xt_reg + TW'(1) >= tw) begin
                    xt_reg <= '0; tx_reg <= tx_reg + XW'(1);
                end else begin
                    xt_reg <= xt_reg + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_phase_reg <= 1'b0;
        end else begin
            read_phase_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rtad_pkg::ST_READ && !read_phase_reg && active_reg) begin
            mem[addr_reg] <= new_sum;
        end
        if (start) fd_reg <= last_reg;
    end

    rtad_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .sums    (new_sum),
        .count   (count_reg),
        .ctrl    (dctrl),
        .mean_r  (div_mean_r),
        .mean_g  (div_mean_g),
        .mean_b  (div_mean_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mean_r_reg  <= div_mean_r;
            mean_g_reg  <= div_mean_g;
            mean_b_reg  <= div_mean_b;
            col_out_reg <= col_reg;
            row_out_reg <= row_reg;
            fd_out_reg  <= fd_reg;
        end
    end

    assign m_mean_red   = mean_r_reg;
    assign m_mean_green = mean_g_reg;
    assign m_mean_blue  = mean_b_reg;
    assign m_tile_col   = col_out_reg;
    assign m_tile_row   = row_out_reg;
    assign m_frame_done = fd_out_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } tile_mean_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_pixel_red;
    logic [7:0]  s_pixel_green;
    logic [7:0]  s_pixel_blue;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_mean_red;
    logic [7:0]  m_mean_green;
    logic [7:0]  m_mean_blue;
    logic [9:0]  m_tile_col;
    logic [9:0]  m_tile_row;
    logic        m_frame_done;

    pixel_t      pixel_queue[$];
    tile_mean_t  tile_means_due[$];
    int unsigned failures;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    bit          steady_send;
    bit          steady_take;

    logic [10:0] frame_w_reg;
    logic [10:0] frame_h_reg;
    logic [6:0]  tile_w_reg;
    logic [6:0]  tile_h_reg;

    int unsigned sum_red[1024];
    int unsigned sum_green[1024];
    int unsigned sum_blue[1024];
    int unsigned pos_x;
    int unsigned pos_y;
    int unsigned sub_x;
    int unsigned sub_y;
    int unsigned tile_x;
    int unsigned tile_y;

    rgb_tile_average_downscale_core DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel_red(s_pixel_red),
        .s_pixel_green(s_pixel_green),
        .s_pixel_blue(s_pixel_blue),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_mean_red(m_mean_red),
        .m_mean_green(m_mean_green),
        .m_mean_blue(m_mean_blue),
        .m_tile_col(m_tile_col),
        .m_tile_row(m_tile_row),
        .m_frame_done(m_frame_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] mean_of(int unsigned total, int unsigned count);
        int unsigned m;
        m = total / count;
        return (m > 255) ? 8'd255 : m[7:0];
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        failures++;
    endtask

    task automatic accumulate_pixel(pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned tw;
        int unsigned th;
        int unsigned tiles_x;
        int unsigned tiles_y;
        tile_mean_t  t;
        w = clamp(frame_w_reg, 1, 1024);
        h = clamp(frame_h_reg, 1, 1024);
        tw = clamp(tile_w_reg, 1, 64);
        th = clamp(tile_h_reg, 1, 64);
        tiles_x = w / tw;
        tiles_y = h / th;
        if (tile_x < tiles_x && tile_y < tiles_y) begin
            if (sub_x == 0 && sub_y == 0) begin
                sum_red[tile_x] = px.red;
                sum_green[tile_x] = px.green;
                sum_blue[tile_x] = px.blue;
            end else begin
                sum_red[tile_x] += px.red;
                sum_green[tile_x] += px.green;
                sum_blue[tile_x] += px.blue;
            end
            if (sub_x == tw - 1 && sub_y == th - 1) begin
                t.red = mean_of(sum_red[tile_x], tw * th);
                t.green = mean_of(sum_green[tile_x], tw * th);
                t.blue = mean_of(sum_blue[tile_x], tw * th);
                t.col = tile_x[9:0];
                t.row = tile_y[9:0];
                t.last = (tile_x == tiles_x - 1) && (tile_y == tiles_y - 1);
                tile_means_due.push_back(t);
            end
        end
        pos_x++;
        sub_x++;
        if (sub_x >= tw) begin
            sub_x = 0;
            tile_x++;
        end
        if (pos_x >= w) begin
            pos_x = 0;
            sub_x = 0;
            tile_x = 0;
            pos_y++;
            sub_y++;
            if (sub_y >= th) begin
                sub_y = 0;
                tile_y++;
            end
            if (pos_y >= h) begin
                pos_y = 0;
                sub_y = 0;
                tile_y = 0;
            end
        end
    endtask

    // Pixel driver and input-side prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_pixel_red <= 8'd0;
            s_pixel_green <= 8'd0;
            s_pixel_blue <= 8'd0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                accumulate_pixel('{s_pixel_red, s_pixel_green, s_pixel_blue});
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_pixel_red <= pixel_queue[0].red;
                    s_pixel_green <= pixel_queue[0].green;
                    s_pixel_blue <= pixel_queue[0].blue;
                    void'(pixel_queue.pop_front());
                    send_gap <= steady_send ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tile_means_due.size() == 0) begin
                    $display("MISMATCH unexpected tile result at %0t", $realtime);
                    failures++;
                end else begin
                    if (m_mean_red !== tile_means_due[0].red)
                        report_mismatch("mean_red", m_mean_red, tile_means_due[0].red);
                    if (m_mean_green !== tile_means_due[0].green)
                        report_mismatch("mean_green", m_mean_green, tile_means_due[0].green);
                    if (m_mean_blue !== tile_means_due[0].blue)
                        report_mismatch("mean_blue", m_mean_blue, tile_means_due[0].blue);
                    if (m_tile_col !== tile_means_due[0].col)
                        report_mismatch("tile_col", m_tile_col, tile_means_due[0].col);
                    if (m_tile_row !== tile_means_due[0].row)
                        report_mismatch("tile_row", m_tile_row, tile_means_due[0].row);
                    if (m_frame_done !== tile_means_due[0].last)
                        report_mismatch("frame_done", m_frame_done, tile_means_due[0].last);
                    void'(tile_means_due.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (steady_take) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // Watchdog on lack of progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_register(logic [1:0] idx, logic [10:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rtad_pkg::REG_IMAGE_WIDTH: frame_w_reg = value;
            rtad_pkg::REG_IMAGE_HEIGHT: frame_h_reg = value;
            rtad_pkg::REG_TILE_WIDTH: tile_w_reg = value[6:0];
            rtad_pkg::REG_TILE_HEIGHT: tile_h_reg = value[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pixel_queue.size() == 0 && !s_valid && tile_means_due.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    // Writes all four registers, then queues the given number of whole frames.
    task automatic run_frames(int unsigned w, int unsigned h, int unsigned tw, int unsigned th,
                              int unsigned frames, int unsigned fill);
        int unsigned n;
        pixel_t      px;
        drain();
        write_register(rtad_pkg::REG_IMAGE_WIDTH, w[10:0]);
        write_register(rtad_pkg::REG_IMAGE_HEIGHT, h[10:0]);
        write_register(rtad_pkg::REG_TILE_WIDTH, tw[10:0]);
        write_register(rtad_pkg::REG_TILE_HEIGHT, th[10:0]);
        n = clamp(w[10:0], 1, 1024) * clamp(h[10:0], 1, 1024) * frames;
        for (int unsigned i = 0; i < n; i++) begin
            case (fill)
                1: px = pixel_t'{8'hFF, 8'hFF, 8'hFF};
                2: px = pixel_t'{8'h00, 8'h00, 8'h00};
                3: px = (i % 2) ? pixel_t'{8'hFF, 8'h00, 8'hFF} :
                                  pixel_t'{8'h00, 8'hFF, 8'h00};
                default: px = pixel_t'{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255))};
            endcase
            pixel_queue.push_back(px);
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 2'd0;
        cfg_data = 11'd0;
        s_valid = 1'b0;
        s_pixel_red = 8'd0;
        s_pixel_green = 8'd0;
        s_pixel_blue = 8'd0;
        m_ready = 1'b0;
        failures = 0;
        steady_send = 1'b0;
        steady_take = 1'b0;
        frame_w_reg = 11'd32;
        frame_h_reg = 11'd32;
        tile_w_reg = 7'd16;
        tile_h_reg = 7'd16;
        pos_x = 0;
        pos_y = 0;
        sub_x = 0;
        sub_y = 0;
        tile_x = 0;
        tile_y = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        run_frames(4, 2, 2, 2, 1, 1);
        run_frames(4, 2, 2, 2, 1, 2);
        run_frames(4, 4, 2, 2, 1, 3);
        run_frames(3, 3, 1, 1, 2, 0);
        run_frames(5, 3, 2, 2, 1, 0);
        run_frames(2, 2, 4, 4, 2, 0);
        run_frames(0, 0, 0, 0, 3, 0);
        run_frames(64, 1, 127, 1, 1, 0);
        run_frames(64, 2, 64, 2, 1, 1);

        sent = 0;
        while (sent < 470) begin
            steady_send = ($urandom_range(0, 3) == 0);
            steady_take = ($urandom_range(0, 3) == 0);
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 8);
            frames = $urandom_range(1, 2);
            run_frames(w, h, $urandom_range(1, 8), $urandom_range(1, 8), frames, 0);
            sent += w * h * frames;
        end
        steady_send = 1'b0;
        steady_take = 1'b0;
        drain();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
